@@ hw/rtl/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; compile this file first.
package uer_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int PULSE_W   = 16;
  localparam int SETTLE_W  = 28;
  localparam int LIMIT_W   = 24;
  localparam int CPCM_W    = 16;
  localparam int DIST_W    = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 28;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_CM = 4'd3;

  // Register reset values.
  localparam logic [PULSE_W-1:0]  PULSE_RST  = 16'd1000;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 28'd100000000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 24'd5000000;
  localparam logic [CPCM_W-1:0]   CPCM_RST   = 16'd3000;

  // Distance reported when the echo count hit the timeout limit.
  localparam logic [DIST_W-1:0] DIST_OOR = '1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SETTLE    = 3'd1,
    PH_PULSE     = 3'd2,
    PH_WAIT_HIGH = 3'd3,
    PH_COUNT     = 3'd4
  } phase_t;

endpackage

@@ hw/rtl/uer_in_if.sv @@
// Input channel of the echo ranger: one tick word with the pin samples.
// Depends on nothing but the valid/ready handshake convention.
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, output start_request, output echo_level, input ready);
  modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

@@ hw/rtl/uer_out_if.sv @@
// Result channel of the echo ranger: trigger level, acknowledge and distance.
// Depends on uer_pkg for the distance width.
interface uer_out_if
  import uer_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic              acknowledge;
  logic              result_valid;
  logic [DIST_W-1:0] distance_cm;
  logic              out_of_range;

  modport source (output valid, output trigger_level, output acknowledge,
                  output result_valid, output distance_cm, output out_of_range,
                  input ready);
  modport sink   (input valid, input trigger_level, input acknowledge,
                  input result_valid, input distance_cm, input out_of_range,
                  output ready);
endinterface

@@ hw/rtl/uer_cfg_if.sv @@
// Configuration write channel of the echo ranger: register index and data.
// Depends on uer_pkg for the index and data widths.
interface uer_cfg_if
  import uer_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: trigger sequencer, echo counter
// and running centimetre count. Depends on uer_pkg and the three channel interfaces.
//
//  Channel   Direction  Word contents
//  in_ch     sink       start_request, echo_level (one word per sample tick)
//  out_ch    source     trigger_level, acknowledge, result_valid, distance_cm,
//                       out_of_range (one word per input word)
//  cfg_ch    sink       index, data (register write)
//
// Every input word produces exactly one output word in the output register.
// One word per cycle is accepted; the path from the input port to the output
// register is a single timer add/compare and the echo counter update.
// rst_n is synchronous and active low; it restores the register defaults and
// returns the sequencer to idle. A stalled output holds in the output register
// and the input channel is stalled only while that register is full and not taken.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int TIMER_BITS = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  uer_in_if.sink     in_ch,
  uer_out_if.source  out_ch,
  uer_cfg_if.sink    cfg_ch
);

  // Compare width covers both the phase timer and the widest phase length.
  localparam int CMP_W = (TIMER_BITS > SETTLE_W) ? TIMER_BITS : SETTLE_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Configuration registers.
  logic [PULSE_W-1:0]  pulse_ticks_r;
  logic [SETTLE_W-1:0] settle_ticks_r;
  logic [LIMIT_W-1:0]  timeout_limit_r;
  logic [CPCM_W-1:0]   counts_per_cm_r;

  // Sequencer state.
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [LIMIT_W-1:0]    echo_count_r, echo_count_nxt;
  logic [CPCM_W-1:0]     sub_count_r, sub_count_nxt;
  logic [DIST_W-1:0]     cm_count_r, cm_count_nxt;
  logic                  trigger_r, trigger_nxt;

  // Output register.
  logic              out_valid_r;
  logic              ack_r, ack_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              oor_r, oor_nxt;

  logic              in_acc;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]  phase_len;
  logic              timer_done;
  logic              can_count;
  logic              at_limit;
  logic [CPCM_W-1:0] sub_inc;
  logic              cm_step;

  // The output register frees up whenever its word is taken, so a new input
  // word can enter in the same cycle.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Phase timer advances and saturates; the phase ends on reaching its length
  // or on saturation. Only settle and pulse phases look at the result.
  assign timer_inc  = (timer_r != TIMER_MAX) ? timer_r + 1'b1 : timer_r;
  assign phase_len  = (phase_r == PH_PULSE) ? CMP_W'(pulse_ticks_r) : CMP_W'(settle_ticks_r);
  assign timer_done = (CMP_W'(timer_inc) >= phase_len) || (timer_inc == TIMER_MAX);

  // Echo counting stops at the timeout limit. The sub-counter rolls over at
  // counts_per_cm and bumps the centimetre count, which replaces a divider.
  assign at_limit  = (echo_count_r >= timeout_limit_r);
  assign can_count = !at_limit;
  assign sub_inc   = sub_count_r + 1'b1;
  assign cm_step   = (sub_inc >= counts_per_cm_r);

  always_comb begin
    phase_nxt      = phase_r;
    timer_nxt      = timer_r;
    echo_count_nxt = echo_count_r;
    sub_count_nxt  = sub_count_r;
    cm_count_nxt   = cm_count_r;
    trigger_nxt    = trigger_r;
    ack_nxt        = 1'b0;
    res_valid_nxt  = 1'b0;
    dist_nxt       = '0;
    oor_nxt        = 1'b0;

    unique case (phase_r)
      PH_SETTLE: begin
        timer_nxt = timer_inc;
        if (timer_done) begin
          timer_nxt   = '0;
          trigger_nxt = 1'b0;
          phase_nxt   = PH_PULSE;
        end
      end
      PH_PULSE: begin
        timer_nxt = timer_inc;
        if (timer_done) begin
          timer_nxt   = '0;
          trigger_nxt = 1'b1;
          phase_nxt   = PH_WAIT_HIGH;
        end
      end
      PH_WAIT_HIGH, PH_COUNT: begin
        if (!in_ch.echo_level) begin
          // The first low tick already counts.
          phase_nxt = PH_COUNT;
          if (can_count) begin
            echo_count_nxt = echo_count_r + 1'b1;
            sub_count_nxt  = cm_step ? '0 : sub_inc;
            cm_count_nxt   = cm_step ? cm_count_r + 1'b1 : cm_count_r;
          end
        end else if (phase_r == PH_COUNT) begin
          // Echo rose again: report and go back to settling.
          res_valid_nxt  = 1'b1;
          oor_nxt        = at_limit;
          dist_nxt       = at_limit ? DIST_OOR : cm_count_r;
          echo_count_nxt = '0;
          sub_count_nxt  = '0;
          cm_count_nxt   = '0;
          timer_nxt      = '0;
          phase_nxt      = PH_SETTLE;
        end
      end
      default: begin
        // Idle, and any code outside the phase list, waits for a start.
        phase_nxt = PH_IDLE;
        if (in_ch.start_request) begin
          ack_nxt     = 1'b1;
          trigger_nxt = 1'b1;
          timer_nxt   = '0;
          phase_nxt   = PH_SETTLE;
        end
      end
    endcase
  end

  // Configuration writes land at once; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r   <= PULSE_RST;
      settle_ticks_r  <= SETTLE_RST;
      timeout_limit_r <= LIMIT_RST;
      counts_per_cm_r <= CPCM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PULSE_TICKS:   pulse_ticks_r   <= cfg_ch.data[PULSE_W-1:0];
        CFG_SETTLE_TICKS:  settle_ticks_r  <= cfg_ch.data[SETTLE_W-1:0];
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_ch.data[LIMIT_W-1:0];
        CFG_COUNTS_PER_CM: counts_per_cm_r <= cfg_ch.data[CPCM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state moves one step per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      timer_r      <= '0;
      echo_count_r <= '0;
      sub_count_r  <= '0;
      cm_count_r   <= '0;
      trigger_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      timer_r      <= timer_nxt;
      echo_count_r <= echo_count_nxt;
      sub_count_r  <= sub_count_nxt;
      cm_count_r   <= cm_count_nxt;
      trigger_r    <= trigger_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The result word carries the trigger level after this tick.
  logic trig_out_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      trig_out_r  <= trigger_nxt;
      ack_r       <= ack_nxt;
      res_valid_r <= res_valid_nxt;
      dist_r      <= dist_nxt;
      oor_r       <= oor_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = trig_out_r;
  assign out_ch.acknowledge   = ack_r;
  assign out_ch.result_valid  = res_valid_r;
  assign out_ch.distance_cm   = dist_r;
  assign out_ch.out_of_range  = oor_r;

  // Every accepted word leaves a word in the output register.
  a_acc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word did not reach the output register");

  // Idle holds the trigger low and an empty echo count.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (!trigger_r && echo_count_r == '0 && cm_count_r == '0))
    else $error("idle phase with live trigger or count");

  // An acknowledge always comes with the trigger raised.
  a_ack_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ack_r) |-> trig_out_r)
    else $error("acknowledge without trigger high");

  // Out of range only appears on a result word and carries the all-ones distance.
  a_oor_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oor_r) |-> (res_valid_r && dist_r == DIST_OOR))
    else $error("out of range flag on a malformed word");

endmodule
